// ===== sv/path_source_mode_arbiter_core_defines.svh =====
// Assertion helpers for the result-channel checker.
`ifndef PATH_SOURCE_MODE_ARBITER_CORE_DEFINES_SVH
`define PATH_SOURCE_MODE_ARBITER_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while in reset.
`define PSMA_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: assertion failed");

// Next-cycle implication, sampled on clk, off while in reset.
`define PSMA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: assertion failed");

`endif

// ===== sv/psma_pkg.sv =====
// ----------------------------------------------------------------------------
// psma_pkg
// Types and codes shared by the path source mode arbiter.
// ----------------------------------------------------------------------------
`default_nettype none

package psma_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;
    localparam int TIME_W      = 32;
    localparam int POS_W       = 16;
    localparam int HW_W        = 15;
    localparam int EXT_W       = 18;   // position +/- radius, no overflow

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_BOX_MIN_X      = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_BOX_MAX_X      = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_BOX_HALF_WIDTH = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_ENGAGE_TIME    = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_RELEASE_TIME   = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_FALLBACK_EN    = 3'd5;

    // command codes
    localparam logic CMD_OBSERVE = 1'b0;
    localparam logic CMD_DECIDE  = 1'b1;

    // mode codes
    localparam logic MODE_LANE  = 1'b0;
    localparam logic MODE_AVOID = 1'b1;

    // source codes
    localparam logic [1:0] SRC_NONE  = 2'd0;
    localparam logic [1:0] SRC_LANE  = 2'd1;
    localparam logic [1:0] SRC_LOCAL = 2'd2;

    // reason codes
    localparam logic [2:0] RSN_LANE          = 3'd0;
    localparam logic [2:0] RSN_LANE_STALE    = 3'd1;
    localparam logic [2:0] RSN_AVOID         = 3'd2;
    localparam logic [2:0] RSN_AVOID_FB_LANE = 3'd3;
    localparam logic [2:0] RSN_LOCAL_STALE   = 3'd4;

    // reset values
    localparam logic signed [POS_W-1:0] RST_BOX_MIN_X      = 16'sd0;
    localparam logic signed [POS_W-1:0] RST_BOX_MAX_X      = 16'sd200;
    localparam logic [HW_W-1:0]         RST_BOX_HALF_WIDTH = 15'd30;
    localparam logic [TIME_W-1:0]       RST_ENGAGE_TIME    = 32'd0;
    localparam logic [TIME_W-1:0]       RST_RELEASE_TIME   = 32'd1000;

    typedef struct packed {
        logic                     command;
        logic                     obs_valid;
        logic                     has_obstacle;
        logic signed [POS_W-1:0]  obs_x;
        logic signed [POS_W-1:0]  obs_y;
        logic signed [POS_W-1:0]  obs_radius;
        logic                     lane_path_ok;
        logic                     local_path_ok;
        logic [TIME_W-1:0]        now_time;
    } psma_req_t;

    typedef struct packed {
        logic       mode_out;
        logic [1:0] source_out;
        logic [2:0] reason_out;
    } psma_rsp_t;

    typedef struct packed {
        logic signed [POS_W-1:0] box_min_x;
        logic signed [POS_W-1:0] box_max_x;
        logic [HW_W-1:0]         box_half_width;
        logic [TIME_W-1:0]       engage_time;
        logic [TIME_W-1:0]       release_time;
        logic                    fallback_enable;
    } psma_cfg_t;

endpackage

`default_nettype wire

// ===== sv/psma_if.sv =====
// ----------------------------------------------------------------------------
// psma_req_if / psma_rsp_if
// Valid/ready channels for request and result beats.
// ----------------------------------------------------------------------------
`default_nettype none

interface psma_req_if;
    import psma_pkg::*;

    logic      valid;
    logic      ready;
    psma_req_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface psma_rsp_if;
    import psma_pkg::*;

    logic      valid;
    logic      ready;
    psma_rsp_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== sv/psma_box_check.sv =====
// ----------------------------------------------------------------------------
// psma_box_check
// Tests an obstacle circle against the trigger box.
// ----------------------------------------------------------------------------
`default_nettype none

module psma_box_check (
    input  var psma_pkg::psma_req_t item,
    input  var psma_pkg::psma_cfg_t cfg,
    output logic                    relevant
);
    import psma_pkg::*;

    logic signed [EXT_W-1:0] x_e;
    logic signed [EXT_W-1:0] y_e;
    logic signed [EXT_W-1:0] ay;
    logic signed [EXT_W-1:0] r_e;
    logic signed [EXT_W-1:0] min_e;
    logic signed [EXT_W-1:0] max_e;
    logic signed [EXT_W-1:0] hw_e;
    logic signed [EXT_W-1:0] far_x;
    logic signed [EXT_W-1:0] near_x;
    logic signed [EXT_W-1:0] lat;

    always_comb
    begin
        x_e   = {{(EXT_W-POS_W){item.obs_x[POS_W-1]}}, item.obs_x};
        y_e   = {{(EXT_W-POS_W){item.obs_y[POS_W-1]}}, item.obs_y};
        ay    = y_e[EXT_W-1] ? -y_e : y_e;
        // negative radius clamps to zero
        r_e   = item.obs_radius[POS_W-1] ? '0
              : {{(EXT_W-POS_W+1){1'b0}}, item.obs_radius[POS_W-2:0]};
        min_e = {{(EXT_W-POS_W){cfg.box_min_x[POS_W-1]}}, cfg.box_min_x};
        max_e = {{(EXT_W-POS_W){cfg.box_max_x[POS_W-1]}}, cfg.box_max_x};
        hw_e  = {{(EXT_W-HW_W){1'b0}}, cfg.box_half_width};
        far_x  = x_e + r_e;
        near_x = x_e - r_e;
        lat    = ay - r_e;
        relevant = item.has_obstacle && (far_x >= min_e) && (near_x <= max_e)
                && (lat <= hw_e);
    end

endmodule

`default_nettype wire

// ===== sv/psma_mode_ctrl.sv =====
// ----------------------------------------------------------------------------
// psma_mode_ctrl
// Timestamp state, lane/avoid hysteresis and source selection.
// ----------------------------------------------------------------------------
`default_nettype none

module psma_mode_ctrl (
    input  wire                     clk,
    input  wire                     rst_n,
    input  wire                     fire,
    input  var psma_pkg::psma_req_t item,
    input  wire                     relevant,
    input  var psma_pkg::psma_cfg_t cfg,
    output psma_pkg::psma_rsp_t     result
);
    import psma_pkg::*;

    logic              avoid_reg,     avoid_next;
    logic [TIME_W-1:0] lv_time_reg,   lv_time_next;
    logic              lv_set_reg,    lv_set_next;
    logic [TIME_W-1:0] lr_time_reg,   lr_time_next;
    logic              lr_set_reg,    lr_set_next;
    logic [TIME_W-1:0] rs_time_reg,   rs_time_next;
    logic              rs_set_reg,    rs_set_next;

    logic [TIME_W-1:0] run_age;
    logic [TIME_W-1:0] clear_age;
    logic              engage;
    logic              release_now;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            avoid_reg   <= MODE_LANE;
            lv_time_reg <= '0;
            lv_set_reg  <= 1'b0;
            lr_time_reg <= '0;
            lr_set_reg  <= 1'b0;
            rs_time_reg <= '0;
            rs_set_reg  <= 1'b0;
        end
        else if (fire)
        begin
            avoid_reg   <= avoid_next;
            lv_time_reg <= lv_time_next;
            lv_set_reg  <= lv_set_next;
            lr_time_reg <= lr_time_next;
            lr_set_reg  <= lr_set_next;
            rs_time_reg <= rs_time_next;
            rs_set_reg  <= rs_set_next;
        end
    end

    always_comb
    begin
        avoid_next   = avoid_reg;
        lv_time_next = lv_time_reg;
        lv_set_next  = lv_set_reg;
        lr_time_next = lr_time_reg;
        lr_set_next  = lr_set_reg;
        rs_time_next = rs_time_reg;
        rs_set_next  = rs_set_reg;

        // differences wrap mod 2^32
        run_age     = item.now_time - rs_time_reg;
        clear_age   = lv_time_reg - lr_time_reg;
        engage      = (avoid_reg == MODE_LANE) && rs_set_reg
                   && (run_age >= cfg.engage_time);
        release_now = (avoid_reg == MODE_AVOID) && lv_set_reg && lr_set_reg
                   && (clear_age >= cfg.release_time);

        if (item.command == CMD_OBSERVE)
        begin
            if (item.obs_valid)
            begin
                lv_time_next = item.now_time;
                lv_set_next  = 1'b1;
                if (relevant)
                begin
                    lr_time_next = item.now_time;
                    lr_set_next  = 1'b1;
                    if (!rs_set_reg)
                    begin
                        rs_time_next = item.now_time;
                        rs_set_next  = 1'b1;
                    end
                end
                else
                begin
                    rs_set_next = 1'b0;
                end
            end
        end
        else
        begin
            if (engage)
            begin
                avoid_next = MODE_AVOID;
            end
            else if (release_now)
            begin
                avoid_next  = MODE_LANE;
                lr_set_next = 1'b0;
                rs_set_next = 1'b0;
            end
        end

        result.mode_out = avoid_next;
        if (avoid_next == MODE_LANE)
        begin
            result.source_out = item.lane_path_ok ? SRC_LANE : SRC_NONE;
            result.reason_out = item.lane_path_ok ? RSN_LANE : RSN_LANE_STALE;
        end
        else if (item.local_path_ok)
        begin
            result.source_out = SRC_LOCAL;
            result.reason_out = RSN_AVOID;
        end
        else if (cfg.fallback_enable && item.lane_path_ok)
        begin
            result.source_out = SRC_LANE;
            result.reason_out = RSN_AVOID_FB_LANE;
        end
        else
        begin
            result.source_out = SRC_NONE;
            result.reason_out = RSN_LOCAL_STALE;
        end
    end

endmodule

`default_nettype wire

// ===== sv/path_source_mode_arbiter_core.sv =====
// ----------------------------------------------------------------------------
// path_source_mode_arbiter_core
// Picks lane or local path source from obstacle observations and decides.
//
//   channel  dir  beat            notes
//   req      in   psma_req_t      observe or decide, one per cycle unless stalled
//   rsp      out  psma_rsp_t      one beat per decide, none per observe
//   cfg      in   index + data    write only, taken whenever cfg_we is high
//
// An item is taken into the input register; when it advances, the box check
// and mode logic update the state and, for a decide, load the result
// register, which drives rsp valid. One item per cycle while req is not stalled.
// req stalls only while a decide sits in the input register behind a full,
// stalled result register. rst_n clears the mode, timestamps and valid flags.
// ----------------------------------------------------------------------------
`default_nettype none

module path_source_mode_arbiter_core (
    input  wire                                  clk,
    input  wire                                  rst_n,
    psma_req_if.sink                             req,
    psma_rsp_if.source                           rsp,
    input  wire                                  cfg_we,
    input  wire [psma_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  wire [psma_pkg::CFG_DATA_W-1:0]       cfg_data
);
    import psma_pkg::*;

    psma_cfg_t cfg_reg;
    psma_req_t item_reg;
    logic      item_valid_reg;
    psma_rsp_t rsp_data_reg;
    logic      rsp_valid_reg;

    logic      is_decide;
    logic      advance;
    logic      relevant;
    psma_rsp_t result;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.box_min_x       <= RST_BOX_MIN_X;
            cfg_reg.box_max_x       <= RST_BOX_MAX_X;
            cfg_reg.box_half_width  <= RST_BOX_HALF_WIDTH;
            cfg_reg.engage_time     <= RST_ENGAGE_TIME;
            cfg_reg.release_time    <= RST_RELEASE_TIME;
            cfg_reg.fallback_enable <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_BOX_MIN_X:      cfg_reg.box_min_x      <= cfg_data[POS_W-1:0];
                REG_BOX_MAX_X:      cfg_reg.box_max_x      <= cfg_data[POS_W-1:0];
                REG_BOX_HALF_WIDTH: cfg_reg.box_half_width <= cfg_data[HW_W-1:0];
                REG_ENGAGE_TIME:    cfg_reg.engage_time    <= cfg_data[TIME_W-1:0];
                REG_RELEASE_TIME:   cfg_reg.release_time   <= cfg_data[TIME_W-1:0];
                REG_FALLBACK_EN:    cfg_reg.fallback_enable <= cfg_data[0];
                default: ;
            endcase
        end
    end

    assign is_decide = (item_reg.command == CMD_DECIDE);
    assign advance   = item_valid_reg && (!is_decide || !rsp_valid_reg || rsp.ready);
    assign req.ready = !item_valid_reg || advance;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (req.ready)
        begin
            item_valid_reg <= req.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            item_reg <= req.data;
        end
    end

    psma_box_check u_box (
        .item     (item_reg),
        .cfg      (cfg_reg),
        .relevant (relevant)
    );

    psma_mode_ctrl u_mode (
        .clk      (clk),
        .rst_n    (rst_n),
        .fire     (advance),
        .item     (item_reg),
        .relevant (relevant),
        .cfg      (cfg_reg),
        .result   (result)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (advance && is_decide)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && is_decide)
        begin
            rsp_data_reg <= result;
        end
    end

    assign rsp.valid = rsp_valid_reg;
    assign rsp.data  = rsp_data_reg;

endmodule

`default_nettype wire

// ===== sv/psma_checker.sv =====
// ----------------------------------------------------------------------------
// psma_checker
// Port-level checks on the arbiter's result channel.
// ----------------------------------------------------------------------------
`default_nettype none
`include "path_source_mode_arbiter_core_defines.svh"

module psma_checker (
    input  wire       clk,
    input  wire       rst_n,
    input  wire       rsp_valid,
    input  wire       rsp_ready,
    input  wire       mode_out,
    input  wire [1:0] source_out,
    input  wire [2:0] reason_out
);
    import psma_pkg::*;

    logic stalled;
    logic lane_reason;

    assign stalled     = rsp_valid && !rsp_ready;
    assign lane_reason = (reason_out == RSN_LANE) || (reason_out == RSN_LANE_STALE);

    // a stalled beat stays put
    `PSMA_ASSERT_NEXT(a_rsp_hold, clk, rst_n, stalled,
        rsp_valid && $stable(mode_out) && $stable(source_out) && $stable(reason_out))

    // lane mode only gives lane reasons, avoid mode never does
    `PSMA_ASSERT_SAME(a_mode_reason, clk, rst_n, rsp_valid,
        (mode_out == MODE_LANE) == lane_reason)

    // local path only in avoid mode with the avoid reason
    `PSMA_ASSERT_SAME(a_local_src, clk, rst_n, rsp_valid && (source_out == SRC_LOCAL),
        (mode_out == MODE_AVOID) && (reason_out == RSN_AVOID))

    // no source means a stale reason
    `PSMA_ASSERT_SAME(a_none_src, clk, rst_n, rsp_valid && (source_out == SRC_NONE),
        (reason_out == RSN_LANE_STALE) || (reason_out == RSN_LOCAL_STALE))

endmodule

bind path_source_mode_arbiter_core psma_checker u_psma_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .rsp_valid  (rsp.valid),
    .rsp_ready  (rsp.ready),
    .mode_out   (rsp.data.mode_out),
    .source_out (rsp.data.source_out),
    .reason_out (rsp.data.reason_out)
);

`default_nettype wire

// ===== sim/psma_checker.sv =====
// ----------------------------------------------------------------------------
// psma_tb_checker
// Watches the request, result and register ports of the path source mode
// arbiter. It keeps its own copy of the mode, timestamps and registers,
// predicts the result of every decide beat and compares each result beat
// against the oldest prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module psma_tb_checker (
    input  wire                             clk,
    input  wire                             rst_n,
    input  wire                             req_valid,
    input  wire                             req_ready,
    input  var psma_pkg::psma_req_t         req_data,
    input  wire                             rsp_valid,
    input  wire                             rsp_ready,
    input  var psma_pkg::psma_rsp_t         rsp_data,
    input  wire                             cfg_we,
    input  wire [psma_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire [psma_pkg::CFG_DATA_W-1:0]  cfg_data,
    output int                              fail_count,
    output int                              decisions_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import psma_pkg::*;

    psma_cfg_t         regs;
    logic              avoid_mode;
    logic [TIME_W-1:0] valid_ts;
    logic [TIME_W-1:0] relevant_ts;
    logic [TIME_W-1:0] run_start_ts;
    logic              valid_seen;
    logic              relevant_seen;
    logic              run_open;
    psma_rsp_t         decisions_due[$];

    // Exact integer overlap test; a negative radius counts as zero.
    function automatic logic obstacle_in_box(psma_req_t item);
        int x;
        int ay;
        int r;
        x  = int'(item.obs_x);
        ay = int'(item.obs_y);
        r  = int'(item.obs_radius);
        if (ay < 0)
        begin
            ay = -ay;
        end
        if (r < 0)
        begin
            r = 0;
        end
        if (x + r < int'(regs.box_min_x) || x - r > int'(regs.box_max_x))
        begin
            return 1'b0;
        end
        return (ay - r) <= int'(regs.box_half_width);
    endfunction

    task automatic take_item(psma_req_t item);
        logic              hit;
        logic [TIME_W-1:0] age;
        psma_rsp_t         res;
        if (item.command == CMD_OBSERVE)
        begin
            if (!item.obs_valid)
            begin
                return;
            end
            hit        = item.has_obstacle && obstacle_in_box(item);
            valid_ts   = item.now_time;
            valid_seen = 1'b1;
            if (hit)
            begin
                relevant_ts   = item.now_time;
                relevant_seen = 1'b1;
                if (!run_open)
                begin
                    run_start_ts = item.now_time;
                    run_open     = 1'b1;
                end
            end
            else
            begin
                run_open = 1'b0;
            end
            return;
        end

        if (avoid_mode == MODE_LANE)
        begin
            age = item.now_time - run_start_ts;
            if (run_open && age >= regs.engage_time)
            begin
                avoid_mode = MODE_AVOID;
            end
        end
        else
        begin
            age = valid_ts - relevant_ts;
            if (valid_seen && relevant_seen && age >= regs.release_time)
            begin
                avoid_mode    = MODE_LANE;
                relevant_seen = 1'b0;
                run_open      = 1'b0;
            end
        end

        res.mode_out = avoid_mode;
        if (avoid_mode == MODE_LANE)
        begin
            res.source_out = item.lane_path_ok ? SRC_LANE : SRC_NONE;
            res.reason_out = item.lane_path_ok ? RSN_LANE : RSN_LANE_STALE;
        end
        else if (item.local_path_ok)
        begin
            res.source_out = SRC_LOCAL;
            res.reason_out = RSN_AVOID;
        end
        else if (regs.fallback_enable && item.lane_path_ok)
        begin
            res.source_out = SRC_LANE;
            res.reason_out = RSN_AVOID_FB_LANE;
        end
        else
        begin
            res.source_out = SRC_NONE;
            res.reason_out = RSN_LOCAL_STALE;
        end
        decisions_due.push_back(res);
    endtask

    task automatic check_decision(psma_rsp_t got);
        psma_rsp_t want;
        if (decisions_due.size() == 0)
        begin
            $error("result beat with nothing expected: mode_out %0d source_out %0d %s %0d",
                   got.mode_out, got.source_out, "reason_out", got.reason_out);
            fail_count++;
            return;
        end
        want = decisions_due.pop_front();
        if (got.mode_out !== want.mode_out)
        begin
            $error("mode_out: expected %0d, actual %0d", want.mode_out, got.mode_out);
            fail_count++;
        end
        if (got.source_out !== want.source_out)
        begin
            $error("source_out: expected %0d, actual %0d", want.source_out, got.source_out);
            fail_count++;
        end
        if (got.reason_out !== want.reason_out)
        begin
            $error("reason_out: expected %0d, actual %0d", want.reason_out, got.reason_out);
            fail_count++;
        end
    endtask

    task automatic write_reg(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] value);
        case (index)
            REG_BOX_MIN_X:      regs.box_min_x       = value[POS_W-1:0];
            REG_BOX_MAX_X:      regs.box_max_x       = value[POS_W-1:0];
            REG_BOX_HALF_WIDTH: regs.box_half_width  = value[HW_W-1:0];
            REG_ENGAGE_TIME:    regs.engage_time     = value[TIME_W-1:0];
            REG_RELEASE_TIME:   regs.release_time    = value[TIME_W-1:0];
            REG_FALLBACK_EN:    regs.fallback_enable = value[0];
            default: ;
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs.box_min_x       = RST_BOX_MIN_X;
            regs.box_max_x       = RST_BOX_MAX_X;
            regs.box_half_width  = RST_BOX_HALF_WIDTH;
            regs.engage_time     = RST_ENGAGE_TIME;
            regs.release_time    = RST_RELEASE_TIME;
            regs.fallback_enable = 1'b0;
            avoid_mode           = MODE_LANE;
            valid_ts             = '0;
            relevant_ts          = '0;
            run_start_ts         = '0;
            valid_seen           = 1'b0;
            relevant_seen        = 1'b0;
            run_open             = 1'b0;
            fail_count           = 0;
            decisions_due.delete();
        end
        else
        begin
            if (rsp_valid && rsp_ready)
            begin
                check_decision(rsp_data);
            end
            if (req_valid && req_ready)
            begin
                take_item(req_data);
            end
            if (cfg_we)
            begin
                write_reg(cfg_index, cfg_data);
            end
        end
        decisions_pending = decisions_due.size();
    end

endmodule

`default_nettype wire

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the path source mode arbiter: a directed opening, then
// obstacle episodes with random content under several register settings and
// idle patterns, including a long result stall. psma_tb_checker does the
// prediction and comparison; this module drives and gives the verdict.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import psma_pkg::*;

    localparam int CYCLE_LIMIT = 500000;
    localparam int DRAIN_WAIT  = 8;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_6 = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_7 = 3'd7;

    logic clk;
    logic rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    int                     fail_count;
    int                     decisions_pending;

    psma_req_if req_ch();
    psma_rsp_if rsp_ch();

    // stimulus-side view of the box and time
    int                box_lo;
    int                box_hi;
    int                box_hw;
    logic [TIME_W-1:0] now_ms;
    int                step_span;
    int                snd_idle_pct;
    int                rcv_idle_pct;
    int                rsp_hold;
    int                cycle_count;

    path_source_mode_arbiter_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .rsp       (rsp_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    psma_tb_checker checker_i (
        .clk               (clk),
        .rst_n             (rst_n),
        .req_valid         (req_ch.valid),
        .req_ready         (req_ch.ready),
        .req_data          (req_ch.data),
        .rsp_valid         (rsp_ch.valid),
        .rsp_ready         (rsp_ch.ready),
        .rsp_data          (rsp_ch.data),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .fail_count        (fail_count),
        .decisions_pending (decisions_pending)
    );

    initial clk = 1'b0;
    always #2 clk = ~clk;

    function automatic int clamp16(int v);
        if (v > 32767)
        begin
            return 32767;
        end
        if (v < -32768)
        begin
            return -32768;
        end
        return v;
    endfunction

    function automatic psma_req_t random_item();
        logic [95:0] bits;
        psma_req_t   item;
        bits = {$urandom, $urandom, $urandom};
        item = bits[$bits(psma_req_t)-1:0];
        return item;
    endfunction

    function automatic psma_req_t decide_item();
        psma_req_t item;
        item          = random_item();
        item.command  = CMD_DECIDE;
        item.now_time = now_ms;
        return item;
    endfunction

    function automatic psma_req_t observe_at(logic v, logic h, int x, int y, int r);
        psma_req_t item;
        item              = random_item();
        item.command      = CMD_OBSERVE;
        item.obs_valid    = v;
        item.has_obstacle = h;
        item.obs_x        = 16'(clamp16(x));
        item.obs_y        = 16'(clamp16(y));
        item.obs_radius   = 16'(clamp16(r));
        item.now_time     = now_ms;
        return item;
    endfunction

    // Aims at the box (or just past an edge) from the current register view.
    function automatic psma_req_t observe_item(logic hit_wanted);
        int   x;
        int   y;
        int   r;
        int   rr;
        logic h;
        h  = 1'b1;
        r  = ($urandom_range(99) < 10) ? -int'($urandom_range(1, 32768))
                                       : int'($urandom_range(0, 60));
        rr = (r < 0) ? 0 : r;
        if (box_lo <= box_hi)
        begin
            x = box_lo + int'($urandom_range(0, box_hi - box_lo));
        end
        else
        begin
            x = $urandom_range(1) ? box_lo : box_hi;
        end
        y = int'($urandom_range(0, box_hw + rr));
        if (hit_wanted)
        begin
            case ($urandom_range(3))
                0: x = box_lo - rr;
                1: x = box_hi + rr;
                default: ;
            endcase
            if ($urandom_range(3) == 0)
            begin
                y = box_hw + rr;
            end
        end
        else
        begin
            case ($urandom_range(3))
                0: h = 1'b0;
                1: x = box_hi + rr + 1 + int'($urandom_range(0, 100));
                2: x = box_lo - rr - 1 - int'($urandom_range(0, 100));
                default: y = box_hw + rr + 1 + int'($urandom_range(0, 100));
            endcase
        end
        if ($urandom_range(1))
        begin
            y = -y;
        end
        return observe_at(1'b1, h, x, y, r);
    endfunction

    task automatic advance_time();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 80)
        begin
            now_ms += $urandom_range(0, step_span);
        end
        else if (pick < 95)
        begin
            now_ms += $urandom_range(0, 20 * step_span);
        end
        else if (pick < 97)
        begin
            now_ms -= 1;
        end
        else
        begin
            now_ms += $urandom;
        end
    endtask

    task automatic send(psma_req_t item);
        while ($urandom_range(99) < snd_idle_pct)
        begin
            @(negedge clk);
            req_ch.valid <= 1'b0;
        end
        @(negedge clk);
        req_ch.valid <= 1'b1;
        req_ch.data  <= item;
        @(posedge clk);
        while (!req_ch.ready)
        begin
            @(posedge clk);
        end
    endtask

    // Observes give no result, so allow the pipeline to finish after the last one.
    task automatic wait_idle();
        @(negedge clk);
        req_ch.valid <= 1'b0;
        while (decisions_pending != 0)
        begin
            @(negedge clk);
        end
        repeat (4) @(negedge clk);
    endtask

    task automatic put_reg(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
    endtask

    task automatic configure(int lo, int hi, int hw, logic [TIME_W-1:0] engage,
                             logic [TIME_W-1:0] release_ms, logic fb);
        wait_idle();
        // upper bits are junk; only the register width counts
        put_reg(REG_BOX_MIN_X, {16'($urandom), 16'(lo)});
        put_reg(REG_BOX_MAX_X, {16'($urandom), 16'(hi)});
        put_reg(REG_BOX_HALF_WIDTH, {17'($urandom), 15'(hw)});
        put_reg(REG_ENGAGE_TIME, engage);
        put_reg(REG_RELEASE_TIME, release_ms);
        put_reg(REG_FALLBACK_EN, {31'($urandom), fb});
        put_reg(REG_SPARE_6, $urandom);
        put_reg(REG_SPARE_7, $urandom);
        @(negedge clk);
        cfg_we <= 1'b0;
        box_lo = lo;
        box_hi = hi;
        box_hw = hw;
    endtask

    task automatic run_random(int target);
        int        done;
        int        kind;
        psma_req_t item;
        done = 0;
        while (done < target)
        begin
            kind = $urandom_range(9);
            if (kind < 6)
            begin
                // relevant run, then clear observations, decides in between
                repeat ($urandom_range(1, 6))
                begin
                    advance_time();
                    send(observe_item($urandom_range(99) < 85));
                    done++;
                    if ($urandom_range(1))
                    begin
                        advance_time();
                        send(decide_item());
                        done++;
                    end
                end
                repeat ($urandom_range(1, 6))
                begin
                    advance_time();
                    send(observe_item($urandom_range(99) < 10));
                    done++;
                    if ($urandom_range(1))
                    begin
                        send(decide_item());
                        done++;
                    end
                end
                send(decide_item());
                done++;
            end
            else if (kind < 8)
            begin
                item = random_item();
                send(item);
                if (item.command == CMD_DECIDE || item.obs_valid)
                begin
                    done++;
                end
            end
            else
            begin
                advance_time();
                send(observe_at(1'b0, 1'b1, box_lo, 0, 0));
                send(decide_item());
                done++;
            end
        end
    endtask

    // receiver: random stalls, plus a counted hold-off when rsp_hold is set
    initial
    begin
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (rsp_hold > 0)
            begin
                rsp_ch.ready <= 1'b0;
                rsp_hold--;
            end
            else
            begin
                rsp_ch.ready <= ($urandom_range(99) >= rcv_idle_pct);
            end
        end
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("tb_top NOT OK");
        $finish;
    end

    initial
    begin
        rst_n        = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.data  = '0;
        cfg_we       = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        rsp_hold     = 0;
        box_lo       = int'(RST_BOX_MIN_X);
        box_hi       = int'(RST_BOX_MAX_X);
        box_hw       = int'(RST_BOX_HALF_WIDTH);
        now_ms       = '0;
        step_span    = 400;
        snd_idle_pct = 9;
        rcv_idle_pct = 83;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed opening under the reset register values
        send(observe_at(1'b1, 1'b1, -32768, 32767, -32768));
        send(decide_item());
        now_ms = 5;
        send(observe_at(1'b0, 1'b1, 100, 0, 10));       // invalid: no effect
        send(decide_item());
        now_ms = 10;
        send(observe_at(1'b1, 1'b1, -32768, -32768, 32767));
        send(observe_at(1'b1, 1'b1, 32767, 32767, -1));   // negative radius
        now_ms = 20;
        send(observe_at(1'b1, 1'b1, -20, -50, 20));     // touches near and side edges
        send(decide_item());
        send(decide_item());
        now_ms = 500;
        send(observe_at(1'b1, 1'b0, 100, 0, 0));
        send(decide_item());
        now_ms = 1019;
        send(observe_at(1'b1, 1'b1, 220, 0, 20));       // touches far edge
        now_ms = 1020;
        send(observe_at(1'b1, 1'b1, 221, 0, 20));
        send(decide_item());
        now_ms = 2019;
        send(observe_at(1'b1, 1'b1, 100, 31, 0));       // release exactly at the limit
        send(decide_item());
        now_ms = 2020;
        send(observe_at(1'b1, 1'b1, 100, 32767, 32767));
        send(decide_item());
        send(decide_item());
        run_random(300);

        configure(-100, 300, 80, 40, 120, 1'b1);
        step_span = 30;
        run_random(320);

        snd_idle_pct = 83;
        rcv_idle_pct = 9;
        configure(-32768, 32767, 32767, 32'hFFFF_FFFF, 32'd0, 1'b0);
        now_ms = 32'hFFFF_FF00;
        step_span = 5;
        // engage with the longest wait: decide one ms before the run start
        send(observe_at(1'b1, 1'b1, 0, 0, 0));
        now_ms -= 1;
        send(decide_item());
        now_ms += 2;
        send(observe_at(1'b1, 1'b0, 0, 0, 0));
        send(decide_item());
        run_random(300);

        configure(500, -500, 0, 32'd0, 32'hFFFF_FFFF, 1'b1);   // inverted box
        step_span = 50;
        run_random(250);

        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        configure(0, 0, 0, 32'd1, 32'd1, 1'b1);
        step_span = 3;
        rsp_hold  = 300;
        run_random(300);

        configure(0, 150, 40, 32'd20, 32'd60, 1'b0);
        step_span = 20;
        run_random(430);

        @(negedge clk);
        req_ch.valid <= 1'b0;
        while (decisions_pending != 0)
        begin
            @(negedge clk);
        end
        repeat (DRAIN_WAIT) @(negedge clk);
        if (fail_count == 0)
        begin
            $display("tb_top OK");
        end
        else
        begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== sim.f =====
+incdir+sv
sv/psma_pkg.sv
sv/psma_if.sv
sv/psma_box_check.sv
sv/psma_mode_ctrl.sv
sv/path_source_mode_arbiter_core.sv
sv/psma_checker.sv
sim/psma_checker.sv
sim/tb_top.sv
